>>> rtl/trimmed_mean_min_max_macros.svh
// Assertion macros for the trimmed mean block.
`ifndef TRIMMED_MEAN_MIN_MAX_MACROS_SVH
`define TRIMMED_MEAN_MIN_MAX_MACROS_SVH
`ifndef SYNTHESIS
`define TRMM_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("trmm check failed");
`define TRMM_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("trmm check failed");
`else
`define TRMM_ASSERT(name, clk, rst_n, expr)
`define TRMM_ASSERT_NEXT(name, clk, rst_n, cond, expr)
`endif
`endif

>>> rtl/trmm_pkg.sv
// Package: widths, constants and types of the trimmed mean block.
package trmm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int BIT_W     = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]    MAX_COUNT    = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] ALL_ONES     = 16'hFFFF;
    localparam logic [CNT_W-1:0]    CNT_TRIM_MIN = 16'd3;
    localparam logic [BIT_W-1:0]    BIT_LAST     = BIT_W'(SUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_TRIM,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/trmm_if.sv
// Word channels of the trimmed mean block: sample input and result output.
interface trmm_in_if;
    logic                         valid;
    logic                         ready;
    logic [trmm_pkg::SAMPLE_W-1:0] sample;
    logic                         last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface trmm_out_if;
    logic                         valid;
    logic                         ready;
    logic [trmm_pkg::SAMPLE_W-1:0] average;
    logic [trmm_pkg::SAMPLE_W-1:0] minimum;
    logic [trmm_pkg::SAMPLE_W-1:0] maximum;

    modport source (output valid, output average, output minimum, output maximum, input ready);
    modport sink   (input valid, input average, input minimum, input maximum, output ready);
endinterface

>>> rtl/trmm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module trmm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trmm_pkg::SUM_W-1:0]    i_dividend,
    input  logic [trmm_pkg::CNT_W-1:0]    i_divisor,
    output trmm_pkg::t_div_stat           o_stat,
    output logic [trmm_pkg::SAMPLE_W-1:0] o_quotient
);

    logic [trmm_pkg::SUM_W-1:0] r_quo;
    logic [trmm_pkg::CNT_W-1:0] r_rem;
    logic [trmm_pkg::CNT_W-1:0] r_den;
    logic [trmm_pkg::BIT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [trmm_pkg::CNT_W:0]   shifted;
    logic [trmm_pkg::CNT_W+1:0] diff;
    logic                       fits;

    assign shifted = {r_rem, r_quo[trmm_pkg::SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign fits    = ~diff[trmm_pkg::CNT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[trmm_pkg::CNT_W-1:0] : shifted[trmm_pkg::CNT_W-1:0];
            r_quo <= {r_quo[trmm_pkg::SUM_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == trmm_pkg::BIT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo[trmm_pkg::SAMPLE_W-1:0];

endmodule

>>> rtl/trimmed_mean_min_max.sv
// Top level: bit-serial trimmed mean with block minimum and maximum.
//
// Usage: samples arrive as words on i_in (sample, last). A block is any run of
// words ending in one with last set; it yields one word on o_out carrying the
// average with one minimum and one maximum removed (three or more samples;
// smaller blocks: plain average), plus the block's minimum and maximum.
// Counts above 65535 saturate; the sum wraps at 32 bits. Each sample is folded
// into the running sum, minimum and maximum one bit per cycle through a 32-bit
// shift loop, and i_in takes no new word until that loop is through. A last
// word adds a bit-serial trim pass (three or more samples), a restoring divide
// and the S_DIVGO and S_OUT control states before the result is registered.
// Reset (synchronous, active low) empties the running state and the output
// register. While the receiver stalls, the finished result is held in the
// output register and the next block is still accepted; a second result waits
// inside the block, and i_in.ready stays low meanwhile, until the first is taken.
module trimmed_mean_min_max (
    input  logic           i_clk,
    input  logic           i_rst_n,
    trmm_in_if.sink        i_in,
    trmm_out_if.source     o_out
);

`include "trimmed_mean_min_max_macros.svh"

    localparam int SW = trmm_pkg::SAMPLE_W;

    trmm_pkg::t_state r_state, n_state;

    logic [trmm_pkg::BIT_W-1:0] r_bit, n_bit;
    logic [trmm_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [SW-1:0]              r_min, n_min;
    logic [SW-1:0]              r_max, n_max;
    logic [trmm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]              r_samp, n_samp;
    logic                       r_last, n_last;
    logic [1:0]                 r_carry, n_carry;
    logic                       r_lt, n_lt;
    logic                       r_gt, n_gt;
    logic                       r_out_valid, n_out_valid;
    logic [SW-1:0]              r_avg, n_avg;
    logic [SW-1:0]              r_omin, n_omin;
    logic [SW-1:0]              r_omax, n_omax;

    logic                       lo_half;
    logic                       samp_bit;
    logic [1:0]                 acc;
    logic [2:0]                 trim;
    logic                       div_start;
    logic [trmm_pkg::CNT_W-1:0] divisor;
    trmm_pkg::t_div_stat        div_stat;
    logic [SW-1:0]              div_quo;

    trmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // n = 0 -> 1, n = 1 -> 1, n = 2 -> 2, otherwise n - 2
    always_comb begin
        if (r_cnt >= trmm_pkg::CNT_TRIM_MIN) begin
            divisor = r_cnt - 16'd2;
        end else if (r_cnt == '0) begin
            divisor = 16'd1;
        end else begin
            divisor = r_cnt;
        end
    end

    assign lo_half  = ~r_bit[trmm_pkg::BIT_W-1];
    assign samp_bit = lo_half & r_samp[0];
    assign acc      = {1'b0, r_sum[0]} + {1'b0, samp_bit} + {1'b0, r_carry[0]};
    // sum + ~min + ~max + 2, one bit per cycle
    assign trim     = {2'b00, r_sum[0]} + {2'b00, ~(lo_half & r_min[0])}
                    + {2'b00, ~(lo_half & r_max[0])} + {1'b0, r_carry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trmm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_min       <= trmm_pkg::ALL_ONES;
            r_max       <= '0;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_carry     <= '0;
            r_lt        <= 1'b0;
            r_gt        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_carry     <= n_carry;
            r_lt        <= n_lt;
            r_gt        <= n_gt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp <= n_samp;
        r_last <= n_last;
        r_avg  <= n_avg;
        r_omin <= n_omin;
        r_omax <= n_omax;
    end

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_cnt       = r_cnt;
        n_samp      = r_samp;
        n_last      = r_last;
        n_carry     = r_carry;
        n_lt        = r_lt;
        n_gt        = r_gt;
        n_out_valid = r_out_valid;
        n_avg       = r_avg;
        n_omin      = r_omin;
        n_omax      = r_omax;
        div_start   = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            trmm_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_samp  = i_in.sample;
                    n_last  = i_in.last;
                    n_bit   = '0;
                    n_carry = '0;
                    n_lt    = 1'b0;
                    n_gt    = 1'b0;
                    if (r_cnt != trmm_pkg::MAX_COUNT) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_state = trmm_pkg::S_ACC;
                end
            end
            trmm_pkg::S_ACC: begin
                n_sum   = {acc[0], r_sum[trmm_pkg::SUM_W-1:1]};
                n_carry = {1'b0, acc[1]};
                n_bit   = r_bit + 1'b1;
                if (lo_half) begin
                    n_samp = {r_samp[0], r_samp[SW-1:1]};
                    n_min  = {r_min[0], r_min[SW-1:1]};
                    n_max  = {r_max[0], r_max[SW-1:1]};
                    if (r_samp[0] != r_min[0]) begin
                        n_lt = ~r_samp[0];
                    end
                    if (r_samp[0] != r_max[0]) begin
                        n_gt = r_samp[0];
                    end
                end
                if (r_bit == trmm_pkg::BIT_LAST) begin
                    if (r_lt) begin
                        n_min = r_samp;
                    end
                    if (r_gt) begin
                        n_max = r_samp;
                    end
                    if (!r_last) begin
                        n_state = trmm_pkg::S_IDLE;
                    end else if (r_cnt >= trmm_pkg::CNT_TRIM_MIN) begin
                        n_carry = 2'd2;
                        n_bit   = '0;
                        n_state = trmm_pkg::S_TRIM;
                    end else begin
                        n_state = trmm_pkg::S_DIVGO;
                    end
                end
            end
            trmm_pkg::S_TRIM: begin
                n_sum   = {trim[0], r_sum[trmm_pkg::SUM_W-1:1]};
                n_carry = trim[2:1];
                n_bit   = r_bit + 1'b1;
                if (lo_half) begin
                    n_min = {r_min[0], r_min[SW-1:1]};
                    n_max = {r_max[0], r_max[SW-1:1]};
                end
                if (r_bit == trmm_pkg::BIT_LAST) begin
                    n_state = trmm_pkg::S_DIVGO;
                end
            end
            trmm_pkg::S_DIVGO: begin
                div_start = 1'b1;
                n_state   = trmm_pkg::S_DIV;
            end
            trmm_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = trmm_pkg::S_OUT;
                end
            end
            trmm_pkg::S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_avg       = div_quo;
                    n_omin      = r_min;
                    n_omax      = r_max;
                    n_sum       = '0;
                    n_min       = trmm_pkg::ALL_ONES;
                    n_max       = '0;
                    n_cnt       = '0;
                    n_state     = trmm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = trmm_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready    = (r_state == trmm_pkg::S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_avg;
    assign o_out.minimum = r_omin;
    assign o_out.maximum = r_omax;

    `TRMM_ASSERT_NEXT(a_accept_starts_acc, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == trmm_pkg::S_ACC)
    `TRMM_ASSERT(a_min_le_max, i_clk, i_rst_n, !(r_state == trmm_pkg::S_IDLE && r_cnt != '0) || (r_min <= r_max))
    `TRMM_ASSERT(a_div_active, i_clk, i_rst_n, r_state != trmm_pkg::S_DIV || div_stat.busy || div_stat.done)
    `TRMM_ASSERT(a_empty_clear, i_clk, i_rst_n, !(r_state == trmm_pkg::S_IDLE && r_cnt == '0) || (r_sum == '0 && r_max == '0))

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for trimmed_mean_min_max: directed and random sample blocks, results scoreboarded.
module tb;

    localparam int LIMIT_CYCLES   = 2_000_000;
    localparam int RANDOM_WORDS   = 1310;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct packed {
        logic [trmm_pkg::SAMPLE_W-1:0] average;
        logic [trmm_pkg::SAMPLE_W-1:0] minimum;
        logic [trmm_pkg::SAMPLE_W-1:0] maximum;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    trmm_in_if  in_if ();
    trmm_out_if out_if ();

    trimmed_mean_min_max u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_result pending_results[$];

    logic [trmm_pkg::SUM_W-1:0]    blk_sum;
    logic [trmm_pkg::SAMPLE_W-1:0] blk_min;
    logic [trmm_pkg::SAMPLE_W-1:0] blk_max;
    logic [trmm_pkg::SAMPLE_W-1:0] blk_first;
    logic [trmm_pkg::CNT_W-1:0]    blk_count;

    int  fail_count   = 0;
    int  words_sent   = 0;
    int  results_seen = 0;
    int  stall_reqs   = 0;
    int  stall_taken  = 0;
    int  cycles       = 0;
    bit  tx_dense     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_block();
        blk_sum   = '0;
        blk_min   = trmm_pkg::ALL_ONES;
        blk_max   = '0;
        blk_first = '0;
        blk_count = '0;
    endfunction

    // Fold one accepted word into the running block; on last, queue the expected word.
    function automatic void fold_sample(input logic [trmm_pkg::SAMPLE_W-1:0] s, input logic l);
        logic [trmm_pkg::SUM_W-1:0]  trimmed;
        logic [trmm_pkg::SUM_W-1:0]  divisor;
        logic [trmm_pkg::SUM_W-1:0]  quot;
        logic [trmm_pkg::SAMPLE_W:0] pair_sum;
        t_result                     res;
        if (blk_count == '0) blk_first = s;
        blk_sum = blk_sum + trmm_pkg::SUM_W'(s);
        if (s > blk_max) blk_max = s;
        if (s < blk_min) blk_min = s;
        if (blk_count < trmm_pkg::MAX_COUNT) blk_count = blk_count + 1'b1;
        if (l) begin
            if (blk_count <= 1) begin
                res.average = s;
            end else if (blk_count == 2) begin
                pair_sum    = {1'b0, blk_first} + {1'b0, s};
                res.average = pair_sum[trmm_pkg::SAMPLE_W:1];
            end else begin
                trimmed = blk_sum - trmm_pkg::SUM_W'(blk_min) - trmm_pkg::SUM_W'(blk_max);
                divisor = trmm_pkg::SUM_W'(blk_count) - 2;
                if (divisor == '0) divisor = 1;
                quot        = trimmed / divisor;
                res.average = quot[trmm_pkg::SAMPLE_W-1:0];
            end
            res.minimum = blk_min;
            res.maximum = blk_max;
            pending_results.push_back(res);
            clear_block();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [trmm_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return trmm_pkg::ALL_ONES;
            2: return trmm_pkg::SAMPLE_W'($urandom_range(0, 15));
            3: return trmm_pkg::ALL_ONES - trmm_pkg::SAMPLE_W'($urandom_range(0, 15));
            default: return trmm_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic [trmm_pkg::SAMPLE_W-1:0] s, input logic l);
        int gap;
        gap = tx_dense ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        in_if.last   <= l;
        do @(posedge i_clk); while (!in_if.ready);
        fold_sample(s, l);
        words_sent++;
    endtask

    task automatic send_block(input int len);
        for (int k = 0; k < len; k++) send_word(pick_sample(), k == len - 1);
    endtask

    task automatic test_single_word_blocks();
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'hAAAA, 1'b1);
        send_word(16'h5555, 1'b1);
    endtask

    task automatic test_pair_blocks();
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0001, 1'b0);
        send_word(16'h0002, 1'b1);
    endtask

    task automatic test_trimmed_blocks();
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0007, 1'b1);
        // duplicated extremes: only one min and one max are dropped
        for (int k = 0; k < 4; k++) send_word(16'h0005, k == 3);
        for (int k = 0; k < 4; k++) send_word(16'hFFFF, k == 3);
    endtask

    // Receiver holds off for a long stretch while short blocks keep coming.
    task automatic test_output_stall();
        stall_reqs++;
        tx_dense = 1'b1;
        for (int b = 0; b < 10; b++) send_block($urandom_range(1, 3));
        tx_dense = 1'b0;
    endtask

    task automatic test_random_blocks();
        int budget;
        int len;
        int r;
        budget = RANDOM_WORDS;
        while (budget > 0) begin
            r = $urandom_range(0, 9);
            if (r < 6)      len = $urandom_range(1, 6);
            else if (r < 9) len = $urandom_range(7, 40);
            else            len = $urandom_range(41, 120);
            if (len > budget) len = budget;
            tx_dense = ($urandom_range(0, 3) == 0);
            send_block(len);
            budget -= len;
        end
        tx_dense = 1'b0;
    endtask

    // output ready pacing
    initial begin : rx_pace
        int hold;
        int run;
        out_if.ready <= 1'b0;
        hold = 0;
        run  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_taken != stall_reqs) begin
                stall_taken = stall_reqs;
                hold        = RX_HOLD_CYCLES;
                run         = 0;
            end
            if (hold == 0 && run == 0) begin
                hold = pick_gap();
                run  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
            end
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
                run--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: avg=%h min=%h max=%h",
                             out_if.average, out_if.minimum, out_if.maximum);
            end else begin
                want = pending_results.pop_front();
                if (out_if.average !== want.average || out_if.minimum !== want.minimum ||
                    out_if.maximum !== want.maximum) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp avg=%h min=%h max=%h, got avg=%h min=%h max=%h",
                                 want.average, want.minimum, want.maximum,
                                 out_if.average, out_if.minimum, out_if.maximum);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        in_if.last   <= 1'b0;
        i_rst_n      <= 1'b0;
        clear_block();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_word_blocks();
        test_pair_blocks();
        test_trimmed_blocks();
        test_output_stall();
        test_random_blocks();
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample words, checked %0d block results, %0d long output stall(s).",
                 words_sent, results_seen, stall_taken);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/trmm_pkg.sv
rtl/trmm_if.sv
rtl/trmm_div.sv
rtl/trimmed_mean_min_max.sv
test/tb.sv
